FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// ante |-> cons, same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante |=> cons, next cycle
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/gfm_pkg.sv
// ---------------------------------------------------------------------------
// gfm_pkg
// Types and constants of the GPS fix / motion state tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package gfm_pkg;

	localparam int THR_W      = 16;
	localparam int TIME_W     = 32;
	localparam int ALPHA_W    = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CODE_W     = 3;

	// one-hot tracker state
	typedef enum logic [4:0] {
		ST_NOFIX = 5'b00001,
		ST_ACQ   = 5'b00010,
		ST_STAT  = 5'b00100,
		ST_MOVE  = 5'b01000,
		ST_LOST  = 5'b10000
	} state_t;

	// external state codes
	localparam logic [CODE_W-1:0] CODE_NOFIX = 3'd0;
	localparam logic [CODE_W-1:0] CODE_ACQ   = 3'd1;
	localparam logic [CODE_W-1:0] CODE_STAT  = 3'd2;
	localparam logic [CODE_W-1:0] CODE_MOVE  = 3'd3;
	localparam logic [CODE_W-1:0] CODE_LOST  = 3'd4;

	// change reasons
	localparam logic [CODE_W-1:0] RSN_NONE     = 3'd0;
	localparam logic [CODE_W-1:0] RSN_TIMEOUT  = 3'd1;
	localparam logic [CODE_W-1:0] RSN_PROLONG  = 3'd2;
	localparam logic [CODE_W-1:0] RSN_FIX      = 3'd3;
	localparam logic [CODE_W-1:0] RSN_HIGH     = 3'd4;
	localparam logic [CODE_W-1:0] RSN_LOW      = 3'd5;
	localparam logic [CODE_W-1:0] RSN_START    = 3'd6;
	localparam logic [CODE_W-1:0] RSN_STOP     = 3'd7;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIX_TO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOST_TO  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOV_THR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STA_THR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd5;

	localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;

	function automatic logic [CODE_W-1:0] state_code(input state_t st);
		logic [CODE_W-1:0] c;
		case (st)
			ST_NOFIX: c = CODE_NOFIX;
			ST_ACQ:   c = CODE_ACQ;
			ST_STAT:  c = CODE_STAT;
			ST_MOVE:  c = CODE_MOVE;
			ST_LOST:  c = CODE_LOST;
			default:  c = CODE_NOFIX;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: sv/gfm_upd_if.sv
// ---------------------------------------------------------------------------
// gfm_upd_if
// Update item channel: fix flag, timestamps and speed sample.
// ---------------------------------------------------------------------------
`default_nettype none

interface gfm_upd_if #(
	parameter int SPEED_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic                   fix_valid;
	logic [31:0]            fix_stamp_ms;
	logic [31:0]            now_ms;
	logic [SPEED_WIDTH-1:0] speed_sample;

	modport source (
		output valid, fix_valid, fix_stamp_ms, now_ms, speed_sample,
		input  ready
	);

	modport sink (
		input  valid, fix_valid, fix_stamp_ms, now_ms, speed_sample,
		output ready
	);
endinterface

`default_nettype wire

FILE: sv/gfm_res_if.sv
// ---------------------------------------------------------------------------
// gfm_res_if
// Result item channel: state, reason, averaged speed and counters.
// ---------------------------------------------------------------------------
`default_nettype none

interface gfm_res_if #(
	parameter int SPEED_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [2:0]             fix_state;
	logic [2:0]             change_reason;
	logic                   state_changed;
	logic [SPEED_WIDTH-1:0] speed_average;
	logic                   gps_seen;
	logic [31:0]            transition_total;

	modport source (
		output valid, fix_state, change_reason, state_changed, speed_average,
		       gps_seen, transition_total,
		input  ready
	);

	modport sink (
		input  valid, fix_state, change_reason, state_changed, speed_average,
		       gps_seen, transition_total,
		output ready
	);
endinterface

`default_nettype wire

FILE: sv/gps_fix_motion_state_tracker.sv
// ---------------------------------------------------------------------------
// gps_fix_motion_state_tracker
// GPS fix / motion state machine with an EMA of ground speed.
// ---------------------------------------------------------------------------
// Takes one update item per clock unless a held result stalls the input, and
// returns one result item per update. An accepted item lands in the input
// register; when the result register is free or being drained, the EMA, the
// fix-age and hold-time checks and the next-state decision are done in one
// pass and written to the result register. The state update loop (two 24x9
// multiplies for the EMA feeding the speed compares, then the state decision)
// sets the item rate. A held result does not stop the input register from
// taking one more item. The user must write config registers through
// cfg_we/cfg_index/cfg_data only while no item is in flight; the block does
// not enforce this. Out-of-range indexes are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gps_fix_motion_state_tracker #(
	parameter int SPEED_WIDTH    = 16,
	parameter int EMA_EXTRA_BITS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	gfm_upd_if.sink                               upd,
	gfm_res_if.source                             res,
	input  wire logic                             cfg_we,
	input  wire logic [gfm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gfm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import gfm_pkg::*;

	// accumulator and arithmetic widths
	localparam int ACC_W  = SPEED_WIDTH + EMA_EXTRA_BITS;
	localparam int PROD_W = ACC_W + ALPHA_W;
	localparam int LVL_W  = THR_W + EMA_EXTRA_BITS;
	localparam int CMP_W  = (ACC_W > LVL_W) ? ACC_W : LVL_W;

	// ---------------- config registers ----------------
	logic [ALPHA_W-1:0] alpha_q;
	logic [TIME_W-1:0]  fix_to_q;
	logic [TIME_W-1:0]  lost_to_q;
	logic [THR_W-1:0]   mov_thr_q;
	logic [THR_W-1:0]   sta_thr_q;
	logic [TIME_W-1:0]  hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= 9'd77;
			fix_to_q  <= 32'd5000;
			lost_to_q <= 32'd10000;
			mov_thr_q <= 16'd256;
			sta_thr_q <= 16'd128;
			hold_q    <= 32'd3000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALPHA:   alpha_q   <= cfg_data[ALPHA_W-1:0];
				REG_FIX_TO:  fix_to_q  <= cfg_data[TIME_W-1:0];
				REG_LOST_TO: lost_to_q <= cfg_data[TIME_W-1:0];
				REG_MOV_THR: mov_thr_q <= cfg_data[THR_W-1:0];
				REG_STA_THR: sta_thr_q <= cfg_data[THR_W-1:0];
				REG_HOLD:    hold_q    <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	// advance: result register free or being drained this cycle
	logic s1_vld_q;
	logic res_vld_q;
	logic adv;
	logic load_res;

	assign adv       = !res_vld_q || res.ready;
	assign upd.ready = !s1_vld_q || adv;
	assign load_res  = s1_vld_q && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (upd.ready) begin
				s1_vld_q <= upd.valid;
			end
			if (adv) begin
				res_vld_q <= s1_vld_q;
			end
		end
	end

	// ---------------- input register ----------------
	logic                   fix_vld_s1;
	logic [TIME_W-1:0]      last_fix_s1;
	logic [TIME_W-1:0]      now_s1;
	logic [SPEED_WIDTH-1:0] speed_s1;

	always_ff @(posedge clk) begin
		if (upd.valid && upd.ready) begin
			fix_vld_s1  <= upd.fix_valid;
			last_fix_s1 <= upd.fix_stamp_ms;
			now_s1      <= upd.now_ms;
			speed_s1    <= upd.speed_sample;
		end
	end

	// ---------------- tracker state ----------------
	state_t             state_q;
	state_t             pend_q;
	logic [TIME_W-1:0]  entered_q;
	logic [TIME_W-1:0]  pend_since_q;
	logic [ACC_W-1:0]   acc_q;
	logic               seen_q;
	logic [TIME_W-1:0]  trans_q;

	// ---------------- EMA ----------------
	// acc = (acc*(256-a) + (sample<<extra)*a + 128) >> 8, a saturated at 256
	logic [ALPHA_W-1:0] a_sat;
	logic [ALPHA_W-1:0] a_inv;
	logic [ACC_W-1:0]   sample_ext;
	logic [PROD_W-1:0]  prod_old;
	logic [PROD_W-1:0]  prod_new;
	logic [PROD_W-1:0]  ema_sum;
	logic [ACC_W-1:0]   acc_nxt;

	assign a_sat      = (alpha_q > ALPHA_FULL) ? ALPHA_FULL : alpha_q;
	assign a_inv      = ALPHA_FULL - a_sat;
	assign sample_ext = ACC_W'(speed_s1) << EMA_EXTRA_BITS;
	assign prod_old   = PROD_W'(acc_q) * PROD_W'(a_inv);
	assign prod_new   = PROD_W'(sample_ext) * PROD_W'(a_sat);
	assign ema_sum    = prod_old + prod_new + PROD_W'(128);
	assign acc_nxt    = ema_sum[ACC_W+7:8];

	// speed compares on the fresh average, thresholds scaled by extra bits
	logic [CMP_W-1:0] acc_cmp;
	logic [CMP_W-1:0] mov_lvl;
	logic [CMP_W-1:0] sta_lvl;
	logic             fast;
	logic             slow;

	assign acc_cmp = CMP_W'(acc_nxt);
	assign mov_lvl = CMP_W'(mov_thr_q) << EMA_EXTRA_BITS;
	assign sta_lvl = CMP_W'(sta_thr_q) << EMA_EXTRA_BITS;
	assign fast    = acc_cmp >= mov_lvl;
	assign slow    = acc_cmp <= sta_lvl;

	// ---------------- fix age ----------------
	logic [TIME_W-1:0] fix_age;
	logic [TIME_W-1:0] lost_age;
	logic              recent;

	assign fix_age  = now_s1 - last_fix_s1;
	assign lost_age = now_s1 - entered_q;
	assign recent   = fix_vld_s1 && (fix_age < fix_to_q);

	// ---------------- next-state decision ----------------
	state_t            desired;
	logic [CODE_W-1:0] reason;

	always_comb begin
		desired = state_q;
		reason  = RSN_NONE;
		if (!recent) begin
			if (state_q != ST_NOFIX && state_q != ST_LOST) begin
				desired = ST_LOST;
				reason  = RSN_TIMEOUT;
			end else if (state_q == ST_LOST && lost_age > lost_to_q) begin
				desired = ST_NOFIX;
				reason  = RSN_PROLONG;
			end
		end else begin
			case (state_q)
				ST_NOFIX, ST_LOST: begin
					desired = ST_ACQ;
					reason  = RSN_FIX;
				end
				ST_ACQ: begin
					if (fast) begin
						desired = ST_MOVE;
						reason  = RSN_HIGH;
					end else if (slow) begin
						desired = ST_STAT;
						reason  = RSN_LOW;
					end
				end
				ST_STAT: begin
					if (fast) begin
						desired = ST_MOVE;
						reason  = RSN_START;
					end
				end
				ST_MOVE: begin
					if (slow) begin
						desired = ST_STAT;
						reason  = RSN_STOP;
					end
				end
				default: ;
			endcase
		end
	end

	// stationary <-> moving needs the change wanted for hold_q ms
	logic              want;
	logic              hold;
	logic              pend_new;
	logic [TIME_W-1:0] since_eff;
	logic [TIME_W-1:0] pend_age;
	logic              commit;

	assign want      = desired != state_q;
	assign hold      = (state_q == ST_STAT && desired == ST_MOVE) ||
	                   (state_q == ST_MOVE && desired == ST_STAT);
	assign pend_new  = pend_q != desired;
	assign since_eff = pend_new ? now_s1 : pend_since_q;
	assign pend_age  = now_s1 - since_eff;
	assign commit    = want && (!hold || (pend_age >= hold_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_NOFIX;
			pend_q       <= ST_NOFIX;
			entered_q    <= '0;
			pend_since_q <= '0;
			acc_q        <= '0;
			seen_q       <= 1'b0;
			trans_q      <= '0;
		end else if (load_res) begin
			acc_q  <= acc_nxt;
			// pending target follows desired when a change is wanted, else the state
			pend_q <= desired;
			if (want && hold && pend_new) begin
				pend_since_q <= now_s1;
			end
			if (commit) begin
				state_q   <= desired;
				entered_q <= now_s1;
				trans_q   <= trans_q + 32'd1;
				if (reason == RSN_FIX) begin
					seen_q <= 1'b1;
				end
			end
		end
	end

	// ---------------- result register ----------------
	logic [CODE_W-1:0]      fix_state_q;
	logic [CODE_W-1:0]      reason_q;
	logic                   changed_q;
	logic [SPEED_WIDTH-1:0] avg_q;
	logic                   seen_out_q;
	logic [TIME_W-1:0]      total_q;

	always_ff @(posedge clk) begin
		if (load_res) begin
			fix_state_q <= state_code(commit ? desired : state_q);
			reason_q    <= commit ? reason : RSN_NONE;
			changed_q   <= commit;
			avg_q       <= acc_nxt[ACC_W-1:EMA_EXTRA_BITS];
			seen_out_q  <= seen_q || (commit && reason == RSN_FIX);
			total_q     <= commit ? trans_q + 32'd1 : trans_q;
		end
	end

	assign res.valid            = res_vld_q;
	assign res.fix_state        = fix_state_q;
	assign res.change_reason    = reason_q;
	assign res.state_changed    = changed_q;
	assign res.speed_average    = avg_q;
	assign res.gps_seen         = seen_out_q;
	assign res.transition_total = total_q;

	// ---------------- assertions ----------------
	`ASSERT_IMP(a_chg_reason, clk, arst_n, res_vld_q, (changed_q == (reason_q != RSN_NONE)), "reason vs flag")
	`ASSERT_IMP(a_fix_acq, clk, arst_n, res_vld_q && changed_q && reason_q == RSN_FIX, (fix_state_q == CODE_ACQ) && seen_out_q, "fix w/o acq")
	`ASSERT_NXT(a_cnt_step, clk, arst_n, load_res && commit, (trans_q == $past(trans_q) + 32'd1), "count missed")
	`ASSERT_NXT(a_s1_hold, clk, arst_n, s1_vld_q && !adv, s1_vld_q, "stalled item dropped")

endmodule

`default_nettype wire
